// ----- rtl/three_plane_intersection_point_core_defines.svh -----
// ----------------------------------------------------------------------------
// three_plane_intersection_point_core_defines
// assertion macros shared by the intersection core
// ----------------------------------------------------------------------------
`ifndef THREE_PLANE_INTERSECTION_POINT_CORE_DEFINES_SVH
`define THREE_PLANE_INTERSECTION_POINT_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define TPIP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define TPIP_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) else $error(msg);

`endif

// ----- rtl/tpip_pkg.sv -----
// ----------------------------------------------------------------------------
// tpip_pkg
// constants and types of the three-plane intersection core
// ----------------------------------------------------------------------------
`default_nettype none

package tpip_pkg;

	// default fraction bits of the fixed-point fields
	localparam int FRAC_BITS_DEF = 16;

	// width of the divider datapath (numerator and divisor magnitudes)
	localparam int WW = 128;

	// quotient bits resolved by the divider, one per stage
	localparam int DIV_BITS = 31;

	// configuration port
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_DET_THRESHOLD = 1'b0;
	localparam logic [31:0] DET_THRESHOLD_RESET = 32'd281474977;

	// saturation limits of a signed 32-bit result
	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	// one stage of the restoring divider, three lanes wide
	typedef struct packed {
		logic [2:0][WW-1:0]       r;
		logic [2:0][DIV_BITS-1:0] q;
		logic [WW-1:0]            dm;
		logic [2:0]               neg;
		logic [2:0]               ov;
		logic                     deg;
		logic [2:0][31:0]         fb;
	} div_t;

endpackage

`default_nettype wire

// ----- rtl/three_plane_intersection_point_core.sv -----
// ----------------------------------------------------------------------------
// three_plane_intersection_point_core
// Takes three planes (normal and offset, signed fixed point) per transaction
// and returns their common point by Cramer's rule, saturated, or the first
// plane's point nearest the origin with degenerate set when |det| is below
// det_threshold or det is zero. One transaction is accepted per cycle while
// s_tready is high. A result passes seven stages of multiply, sum and
// magnitude work, then a restoring divider of one quotient bit per stage
// (31 stages, three lanes), then the output register. A skid register
// behind the output lets the pipeline take one more transaction while a
// result waits; the pipeline stalls only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_plane_intersection_point_core_defines.svh"

module three_plane_intersection_point_core #(
	parameter int FRAC_BITS = tpip_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tpip_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// planes in
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// plane_a_normal_x, _y, _z, plane_a_offset, then plane_b, plane_c alike
	input  wire logic [383:0]                s_tdata,
	// point out
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// point_x, point_y, point_z
	output logic      [95:0]                 m_tdata,
	// degenerate
	output logic      [0:0]                  m_tuser
);

	localparam int W  = tpip_pkg::WW;
	localparam int NB = tpip_pkg::DIV_BITS;

	// configuration register
	logic [31:0] det_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_threshold_q <= tpip_pkg::DET_THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == tpip_pkg::REG_DET_THRESHOLD) begin
			det_threshold_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tpip_pkg::REG_DET_THRESHOLD) ? det_threshold_q : 32'h0;

	// pipeline advance
	logic en;
	logic skid_v_q;

	assign en       = ~skid_v_q;
	assign s_tready = en;

	// unpack input fields
	logic signed [31:0] n_in [3][3];
	logic signed [31:0] d_in [3];

	always_comb begin
		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < 3; i++) begin
				n_in[p][i] = $signed(s_tdata[(p*4+i)*32 +: 32]);
			end
			d_in[p] = $signed(s_tdata[(p*4+3)*32 +: 32]);
		end
	end

	// fallback point -dA*nA truncated and saturated
	function automatic logic [31:0] sat_fb(input logic signed [63:0] prod);
		logic signed [63:0] pr;
		logic [63:0]        mag;
		pr  = -prod;
		mag = pr[63] ? 64'(-pr) : 64'(pr);
		mag = mag >> FRAC_BITS;
		if (pr[63]) begin
			sat_fb = (mag >= 64'h8000_0000) ? tpip_pkg::SAT_NEG : 32'(-mag);
		end else begin
			sat_fb = (mag > 64'h7FFF_FFFF) ? tpip_pkg::SAT_POS : mag[31:0];
		end
	endfunction

	// valid bits of the arithmetic stages
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [NB-1:0] div_vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			vld_s7     <= 1'b0;
			div_vld_s8 <= '0;
		end else if (en) begin
			vld_s1     <= s_tvalid;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			vld_s6     <= vld_s5;
			vld_s7     <= vld_s6;
			div_vld_s8 <= {div_vld_s8[NB-2:0], vld_s7};
		end
	end

	// s1: cross product terms and fallback products
	logic signed [63:0] cp0_s1 [3][3];
	logic signed [63:0] cp1_s1 [3][3];
	logic signed [63:0] fbp_s1 [3];
	logic signed [31:0] na_s1  [3];
	logic signed [31:0] d_s1   [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 3; p++) begin
				for (int i = 0; i < 3; i++) begin
					cp0_s1[p][i] <= n_in[(p+1)%3][(i+1)%3] * n_in[(p+2)%3][(i+2)%3];
					cp1_s1[p][i] <= n_in[(p+1)%3][(i+2)%3] * n_in[(p+2)%3][(i+1)%3];
				end
				fbp_s1[p] <= d_in[0] * n_in[0][p];
				na_s1[p]  <= n_in[0][p];
				d_s1[p]   <= d_in[p];
			end
		end
	end

	// s2: cross products and saturated fallback point
	logic signed [63:0] x_s2  [3][3];
	logic [31:0]        fb_s2 [3];
	logic signed [31:0] na_s2 [3];
	logic signed [31:0] d_s2  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 3; p++) begin
				for (int i = 0; i < 3; i++) begin
					x_s2[p][i] <= cp0_s1[p][i] - cp1_s1[p][i];
				end
				fb_s2[p] <= sat_fb(fbp_s1[p]);
				na_s2[p] <= na_s1[p];
				d_s2[p]  <= d_s1[p];
			end
		end
	end

	// operand pairs: row 0 for det, rows 1 to 3 for the numerator terms
	logic signed [31:0] mul_a [4][3];
	logic signed [63:0] mul_x [4][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mul_a[0][i] = na_s2[i];
			mul_x[0][i] = x_s2[0][i];
			for (int p = 0; p < 3; p++) begin
				mul_a[p+1][i] = d_s2[p];
				mul_x[p+1][i] = x_s2[p][i];
			end
		end
	end

	// s3: split 32 x 64 products into high and low halves
	logic signed [63:0] ph_s3 [4][3];
	logic signed [63:0] pl_s3 [4][3];
	logic [31:0]        fb_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < 4; t++) begin
				for (int i = 0; i < 3; i++) begin
					ph_s3[t][i] <= mul_a[t][i] * $signed(mul_x[t][i][63:32]);
					pl_s3[t][i] <= mul_a[t][i] * $signed({1'b0, mul_x[t][i][31:0]});
				end
			end
			fb_s3 <= fb_s2;
		end
	end

	// s4: recombine partial products
	logic signed [95:0] pr_s4 [4][3];
	logic [31:0]        fb_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < 4; t++) begin
				for (int i = 0; i < 3; i++) begin
					pr_s4[t][i] <= $signed({ph_s3[t][i], 32'h0}) + 96'(pl_s3[t][i]);
				end
			end
			fb_s4 <= fb_s3;
		end
	end

	// s5: determinant and negated numerators
	logic signed [97:0] det_s5;
	logic signed [97:0] num_s5 [3];
	logic [31:0]        fb_s5  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= 98'(pr_s4[0][0]) + 98'(pr_s4[0][1]) + 98'(pr_s4[0][2]);
			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= -(98'(pr_s4[1][i]) + 98'(pr_s4[2][i]) + 98'(pr_s4[3][i]));
			end
			fb_s5 <= fb_s4;
		end
	end

	// magnitudes for the degeneracy test and the divider
	logic [W-1:0] dmag;
	logic [W-1:0] nmag [3];

	always_comb begin
		dmag = det_s5[97] ? W'(-det_s5) : W'(det_s5);
		for (int i = 0; i < 3; i++) begin
			nmag[i] = num_s5[i][97] ? W'(-num_s5[i]) : W'(num_s5[i]);
		end
	end

	// s6: divider operands
	logic [W-1:0] dm_s6;
	logic [W-1:0] nm_s6  [3];
	logic [2:0]   neg_s6;
	logic         deg_s6;
	logic [31:0]  fb_s6  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s6  <= dmag;
			deg_s6 <= (dmag == '0) || (dmag < W'(det_threshold_q));
			for (int i = 0; i < 3; i++) begin
				nm_s6[i]  <= nmag[i] << FRAC_BITS;
				neg_s6[i] <= num_s5[i][97] ^ det_s5[97];
			end
			fb_s6 <= fb_s5;
		end
	end

	// s7: overflow check against det scaled by the quotient range
	tpip_pkg::div_t dv_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s7.dm  <= dm_s6;
			dv_s7.neg <= neg_s6;
			dv_s7.deg <= deg_s6;
			for (int i = 0; i < 3; i++) begin
				dv_s7.r[i]  <= nm_s6[i];
				dv_s7.q[i]  <= '0;
				dv_s7.ov[i] <= nm_s6[i] >= (dm_s6 << NB);
				dv_s7.fb[i] <= fb_s6[i];
			end
		end
	end

	// s8 onwards: restoring divider, one quotient bit per stage
	tpip_pkg::div_t div_s8 [NB];

	for (genvar j = 0; j < NB; j++) begin : g_div
		tpip_pkg::div_t prev;
		tpip_pkg::div_t nxt;

		if (j == 0) begin : g_first
			assign prev = dv_s7;
		end else begin : g_next
			assign prev = div_s8[j-1];
		end

		// trial subtract of the shifted divisor in each lane
		always_comb begin
			logic [W:0] diff;
			nxt = prev;
			for (int l = 0; l < 3; l++) begin
				diff = {1'b0, prev.r[l]} - {1'b0, prev.dm << (NB - 1 - j)};
				if (!diff[W]) begin
					nxt.r[l]           = diff[W-1:0];
					nxt.q[l][NB-1-j]   = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s8[j] <= nxt;
			end
		end
	end

	// result selection
	logic [95:0] res_data;
	logic        res_deg;

	always_comb begin
		res_deg = div_s8[NB-1].deg;
		for (int l = 0; l < 3; l++) begin
			if (div_s8[NB-1].deg) begin
				res_data[l*32 +: 32] = div_s8[NB-1].fb[l];
			end else if (div_s8[NB-1].ov[l]) begin
				res_data[l*32 +: 32] = div_s8[NB-1].neg[l] ? tpip_pkg::SAT_NEG
				                                             : tpip_pkg::SAT_POS;
			end else if (div_s8[NB-1].neg[l]) begin
				res_data[l*32 +: 32] = 32'(-{1'b0, div_s8[NB-1].q[l]});
			end else begin
				res_data[l*32 +: 32] = {1'b0, div_s8[NB-1].q[l]};
			end
		end
	end

	// output register and skid register
	logic        out_v_q;
	logic [95:0] out_data_q;
	logic        out_deg_q;
	logic [95:0] skid_data_q;
	logic        skid_deg_q;
	logic        taken;

	assign taken = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (taken) begin
				skid_v_q <= 1'b0;
			end
		end else if (div_vld_s8[NB-1]) begin
			if (!out_v_q || taken) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (taken) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (taken) begin
				out_data_q <= skid_data_q;
				out_deg_q  <= skid_deg_q;
			end
		end else if (div_vld_s8[NB-1]) begin
			if (!out_v_q || taken) begin
				out_data_q <= res_data;
				out_deg_q  <= res_deg;
			end else begin
				skid_data_q <= res_data;
				skid_deg_q  <= res_deg;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_deg_q;

	// conditions watched by the checks
	logic out_stalled;
	logic rem_ok;

	assign out_stalled = out_v_q && !m_tready && !skid_v_q && div_vld_s8[NB-1];

	always_comb begin
		rem_ok = 1'b1;
		if (div_vld_s8[NB-1] && !div_s8[NB-1].deg) begin
			for (int l = 0; l < 3; l++) begin
				if (!div_s8[NB-1].ov[l] && !(div_s8[NB-1].r[l] < div_s8[NB-1].dm)) begin
					rem_ok = 1'b0;
				end
			end
		end
	end

	// checks
	`TPIP_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid full while output empty")
	`TPIP_ASSERT_NEXT(a_skid_catch, out_stalled, skid_v_q, "stalled result not caught")
	`TPIP_ASSERT(a_rem_below_div, rem_ok, "divider remainder not below divisor")

endmodule

`default_nettype wire
